// File: hw/rtl/abmu_pkg.sv
`timescale 1ns / 1ps

package abmu_pkg;

  // Command codes
  localparam logic [2:0] CMD_SXTB = 3'd0;
  localparam logic [2:0] CMD_SXTH = 3'd1;
  localparam logic [2:0] CMD_UXTB = 3'd2;
  localparam logic [2:0] CMD_UXTH = 3'd3;
  localparam logic [2:0] CMD_UBFX = 3'd4;
  localparam logic [2:0] CMD_SBFX = 3'd5;
  localparam logic [2:0] CMD_CLZ  = 3'd6;
  localparam logic [2:0] CMD_REV  = 3'd7;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned QUEUE_D  = 2;
  localparam int unsigned QPTR_W   = $clog2(QUEUE_D);
  localparam int unsigned QCNT_W   = $clog2(QUEUE_D + 1);

  // Input transaction
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] source_value;
    logic [4:0]  field_lsb;
    logic [5:0]  field_width;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] result_value;
    logic        invalid;
  } out_item_t;

  // Classified operation handed from front to back
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] source_value;
    logic [4:0]  field_lsb;
    logic [31:0] field_mask;  // low field_width ones
    logic [4:0]  sign_pos;    // field_width - 1
    logic        bad_field;   // illegal extract field
  } op_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Leading-zero count, binary search in five halving steps
  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  n;
    x = v;
    n = '0;
    if (x[31:16] == '0) begin n[4] = 1'b1; x = x << 16; end
    if (x[31:24] == '0) begin n[3] = 1'b1; x = x << 8;  end
    if (x[31:28] == '0) begin n[2] = 1'b1; x = x << 4;  end
    if (x[31:30] == '0) begin n[1] = 1'b1; x = x << 2;  end
    if (x[31] == 1'b0)  begin n[0] = 1'b1; end
    return (v == '0) ? 6'd32 : {1'b0, n};
  endfunction

endpackage

// File: hw/rtl/abmu_front.sv
`timescale 1ns / 1ps

module abmu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  abmu_pkg::in_item_t in_item,
  input  abmu_pkg::q_stat_t  q_stat,
  output logic               push,
  output abmu_pkg::op_t      push_op
);
  import abmu_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     take;
  logic [6:0] field_end;

  // Front holds one item; it stalls only when the queue is full
  assign busy    = vld_r & q_stat.full;
  assign take    = start & ~busy;
  assign push    = vld_r & ~q_stat.full;
  assign vld_nxt = take | (vld_r & q_stat.full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  // Classify: field legality, mask and sign position
  assign field_end = {2'b00, item_r.field_lsb} + {1'b0, item_r.field_width};

  always_comb begin
    push_op.command      = item_r.command;
    push_op.source_value = item_r.source_value;
    push_op.field_lsb    = item_r.field_lsb;
    push_op.field_mask   = (32'd1 << item_r.field_width) - 32'd1;
    push_op.sign_pos     = 5'(item_r.field_width - 6'd1);
    push_op.bad_field    = ((item_r.command == CMD_UBFX) || (item_r.command == CMD_SBFX))
                           && ((item_r.field_width == 6'd0) || (field_end > 7'd32));
  end

endmodule

// File: hw/rtl/abmu_queue.sv
`timescale 1ns / 1ps

module abmu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  abmu_pkg::op_t     push_op,
  input  logic              pop,
  output abmu_pkg::op_t     head_op,
  output abmu_pkg::q_stat_t q_stat
);
  import abmu_pkg::*;

  op_t               mem_r [QUEUE_D];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_D));
  assign q_stat.empty = (cnt_r == '0);
  assign head_op      = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: hw/rtl/abmu_back.sv
`timescale 1ns / 1ps

module abmu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  abmu_pkg::q_stat_t   q_stat,
  input  abmu_pkg::op_t       head_op,
  output logic                pop,
  output logic                out_strobe,
  output abmu_pkg::out_item_t out_item
);
  import abmu_pkg::*;

  logic      strobe_r;
  out_item_t item_r, item_nxt;
  logic [31:0] src, shifted, field;

  // Back never stalls: drain one op per cycle
  assign pop = ~q_stat.empty;
  assign src = head_op.source_value;

  // Bitfield extract datapath
  always_comb begin
    shifted = src >> head_op.field_lsb;
    field   = shifted & head_op.field_mask;
    if ((head_op.command == CMD_SBFX) && field[head_op.sign_pos]) begin
      field = field | ~head_op.field_mask;
    end
  end

  // Result select
  always_comb begin
    item_nxt.invalid = 1'b0;
    unique case (head_op.command)
      CMD_SXTB: item_nxt.result_value = {{24{src[7]}}, src[7:0]};
      CMD_SXTH: item_nxt.result_value = {{16{src[15]}}, src[15:0]};
      CMD_UXTB: item_nxt.result_value = {24'd0, src[7:0]};
      CMD_UXTH: item_nxt.result_value = {16'd0, src[15:0]};
      CMD_UBFX, CMD_SBFX: begin
        item_nxt.invalid      = head_op.bad_field;
        item_nxt.result_value = head_op.bad_field ? '0 : field;
      end
      CMD_CLZ:  item_nxt.result_value = {26'd0, clz32(src)};
      CMD_REV:  item_nxt.result_value = {src[7:0], src[15:8], src[23:16], src[31:24]};
      default:  item_nxt.result_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= item_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// File: hw/rtl/arm_bit_manipulation_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                        Transaction taken when
// input     start, busy, in_item         start && !busy at a rising edge
// result    out_strobe, out_item         out_strobe high (one cycle each)
//
// An accepted item passes the front register, the two-entry queue, then
// the registered execute stage in the back part before its result shows.
// One item per cycle is sustained; the back part drains the queue every cycle.
// busy rises only if the queue is full while the front holds an item.
// Reset is synchronous, active low, and clears all valid state.
// The receiver cannot stall, so results never wait.

module arm_bit_manipulation_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  abmu_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output abmu_pkg::out_item_t out_item
);
  import abmu_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  op_t     push_op, head_op;

  abmu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_stat  (q_stat),
    .push    (push),
    .push_op (push_op)
  );

  abmu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .q_stat  (q_stat)
  );

  abmu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_op    (head_op),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// File: hw/rtl/abmu_checker.sv
`timescale 1ns / 1ps

module abmu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input abmu_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input abmu_pkg::out_item_t out_item
);
  import abmu_pkg::*;

  // Every accepted transaction yields a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("accepted transaction produced no result");

  // No result without a matching accepted transaction
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, 3))
    else $error("result without accepted transaction");

  // Invalid results carry zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.invalid) |-> (out_item.result_value == '0))
    else $error("invalid result is not zero");

  // Invalid only arises from extract commands
  a_invalid_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.invalid) |->
      ($past(in_item.command, 3) == CMD_UBFX || $past(in_item.command, 3) == CMD_SBFX))
    else $error("invalid flag on non-extract command");

  // Byte reverse check end to end
  a_rev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_item.command, 3) == CMD_REV) |->
      (out_item.result_value == {$past(in_item.source_value[7:0], 3),
                                 $past(in_item.source_value[15:8], 3),
                                 $past(in_item.source_value[23:16], 3),
                                 $past(in_item.source_value[31:24], 3)}))
    else $error("byte reverse mismatch");

endmodule

bind arm_bit_manipulation_unit abmu_checker u_abmu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// File: bench/tb_arm_bit_manipulation_unit.sv
`timescale 1ns / 1ps

module tb_arm_bit_manipulation_unit;
  import abmu_pkg::*;

  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PRINT_LIMIT  = 50;

  // One directed row: command plus an optional hand-written result
  typedef struct packed {
    in_item_t  item;
    logic      pinned;
    out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  // Hand-written result that travels with the driven item
  logic      row_pinned;
  out_item_t row_result;

  out_item_t   pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned err_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned invalid_count;
  int unsigned idle_count;
  int unsigned cycle_count;

  arm_bit_manipulation_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected result of one command
  function automatic out_item_t bitop_predict(input in_item_t it);
    out_item_t   r;
    logic [31:0] mask;
    int unsigned span;
    int          b;
    r    = '0;
    span = int'(it.field_lsb) + int'(it.field_width);
    case (it.command)
      CMD_SXTB: r.result_value = {{24{it.source_value[7]}}, it.source_value[7:0]};
      CMD_SXTH: r.result_value = {{16{it.source_value[15]}}, it.source_value[15:0]};
      CMD_UXTB: r.result_value = {24'd0, it.source_value[7:0]};
      CMD_UXTH: r.result_value = {16'd0, it.source_value[15:0]};
      CMD_UBFX, CMD_SBFX: begin
        if (it.field_width == 6'd0 || span > 32) begin
          r.invalid = 1'b1;
        end else begin
          mask = (it.field_width == 6'd32) ? 32'hFFFF_FFFF
                                           : ((32'd1 << it.field_width) - 32'd1);
          r.result_value = (it.source_value >> it.field_lsb) & mask;
          // sign bit of the field sits at width - 1
          if (it.command == CMD_SBFX && r.result_value[it.field_width - 6'd1]) begin
            r.result_value = r.result_value | ~mask;
          end
        end
      end
      CMD_CLZ: begin
        // highest set bit wins; all zeros leaves 32
        r.result_value = 32'd32;
        for (b = 0; b < 32; b++) begin
          if (it.source_value[b]) r.result_value = 32'(31 - b);
        end
      end
      CMD_REV: begin
        r.result_value = {it.source_value[7:0], it.source_value[15:8],
                          it.source_value[23:16], it.source_value[31:24]};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic [2:0] cmd, input logic [31:0] src,
                                       input logic [4:0] lsb, input logic [5:0] wid,
                                       input logic pinned, input logic [31:0] want_value,
                                       input logic want_bad);
    stim_row_t row;
    row.item.command      = cmd;
    row.item.source_value = src;
    row.item.field_lsb    = lsb;
    row.item.field_width  = wid;
    row.pinned            = pinned;
    row.result.result_value = want_value;
    row.result.invalid      = want_bad;
    return row;
  endfunction

  // Random command; extracts mostly get a legal field
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.command = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.source_value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    end else if (pick < 40) begin
      // thin out the top bits so leading-zero counts spread
      it.source_value = $urandom >> $urandom_range(31);
    end else begin
      it.source_value = $urandom;
    end
    it.field_lsb = 5'($urandom_range(31));
    if ($urandom_range(99) < 80) begin
      it.field_width = 6'($urandom_range(32 - int'(it.field_lsb), 1));
    end else begin
      it.field_width = 6'($urandom_range(63));
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("[cycle %0d] MISMATCH: %s", cycle_count, what);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %h/%b with no transaction pending",
                                got.result_value, got.invalid));
      return;
    end
    want = pending_results.pop_front();
    checked_count++;
    if (got.invalid) invalid_count++;
    if (got.result_value !== want.result_value) begin
      report_mismatch($sformatf("result_value got %h want %h",
                                got.result_value, want.result_value));
    end
    if (got.invalid !== want.invalid) begin
      report_mismatch($sformatf("invalid got %b want %b", got.invalid, want.invalid));
    end
  endtask

  // Drive one transaction, idling first at the given percentage per cycle
  task automatic send_item(input in_item_t it, input logic pinned, input out_item_t result,
                           input int unsigned idle_pct);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do begin
        @(posedge clk);
        idle_count++;
      end while ($urandom_range(99) < idle_pct);
    end
    start      <= 1'b1;
    in_item    <= it;
    row_pinned <= pinned;
    row_result <= result;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("arm_bit_manipulation_unit verification failed");
      $finish;
    end
  end

  // Record accepted transactions and check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        pending_results.push_back(row_pinned ? row_result : bitop_predict(in_item));
      end
      if (out_strobe) check_result(out_item);
    end
  end

  // Stimulus
  initial begin
    int unsigned idle_pct;
    int          i;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    row_pinned  = 1'b0;
    row_result  = '0;
    err_count   = 0;
    sent_count  = 0;
    checked_count = 0;
    invalid_count = 0;
    idle_count  = 0;
    cycle_count = 0;

    // Directed table: extremes, every command, illegal fields
    directed_rows.push_back(mk_row(CMD_SXTB, 32'h0000_0080, 5'd0, 6'd0, '1, 32'hFFFF_FF80, '0));
    directed_rows.push_back(mk_row(CMD_SXTB, 32'hFFFF_FF7F, 5'd0, 6'd0, '1, 32'h0000_007F, '0));
    directed_rows.push_back(mk_row(CMD_SXTH, 32'h0000_8000, 5'd0, 6'd0, '1, 32'hFFFF_8000, '0));
    directed_rows.push_back(mk_row(CMD_SXTH, 32'hFFFF_7FFF, 5'd0, 6'd0, '1, 32'h0000_7FFF, '0));
    directed_rows.push_back(mk_row(CMD_UXTB, 32'hFFFF_FFFF, 5'd0, 6'd0, '1, 32'h0000_00FF, '0));
    directed_rows.push_back(mk_row(CMD_UXTH, 32'hFFFF_FFFF, 5'd0, 6'd0, '1, 32'h0000_FFFF, '0));
    // full-width extract returns the source
    directed_rows.push_back(mk_row(CMD_UBFX, 32'hDEAD_BEEF, 5'd0, 6'd32, '1, 32'hDEAD_BEEF, '0));
    directed_rows.push_back(mk_row(CMD_SBFX, 32'hDEAD_BEEF, 5'd0, 6'd32, '1, 32'hDEAD_BEEF, '0));
    // illegal fields: zero width, past bit 31, oversized width
    directed_rows.push_back(mk_row(CMD_UBFX, 32'hFFFF_FFFF, 5'd5, 6'd0, '1, 32'h0, '1));
    directed_rows.push_back(mk_row(CMD_SBFX, 32'hFFFF_FFFF, 5'd31, 6'd2, '1, 32'h0, '1));
    directed_rows.push_back(mk_row(CMD_UBFX, 32'hFFFF_FFFF, 5'd0, 6'd63, '1, 32'h0, '1));
    directed_rows.push_back(mk_row(CMD_SBFX, 32'hFFFF_FFFF, 5'd0, 6'd33, '1, 32'h0, '1));
    directed_rows.push_back(mk_row(CMD_UBFX, 32'hFFFF_FFFF, 5'd16, 6'd17, '1, 32'h0, '1));
    // single top bit
    directed_rows.push_back(mk_row(CMD_SBFX, 32'h8000_0000, 5'd31, 6'd1, '1, 32'hFFFF_FFFF, '0));
    directed_rows.push_back(mk_row(CMD_UBFX, 32'h8000_0000, 5'd31, 6'd1, '1, 32'h0000_0001, '0));
    directed_rows.push_back(mk_row(CMD_UBFX, 32'h1234_5678, 5'd4, 6'd8, '0, 32'h0, '0));
    directed_rows.push_back(mk_row(CMD_SBFX, 32'h00F8_0000, 5'd8, 6'd12, '0, 32'h0, '0));
    directed_rows.push_back(mk_row(CMD_SBFX, 32'h8000_0000, 5'd16, 6'd16, '0, 32'h0, '0));
    // leading zeros of zero is 32
    directed_rows.push_back(mk_row(CMD_CLZ, 32'h0000_0000, 5'd0, 6'd0, '1, 32'd32, '0));
    directed_rows.push_back(mk_row(CMD_CLZ, 32'hFFFF_FFFF, 5'd0, 6'd0, '1, 32'd0, '0));
    directed_rows.push_back(mk_row(CMD_CLZ, 32'h0000_0001, 5'd0, 6'd0, '1, 32'd31, '0));
    directed_rows.push_back(mk_row(CMD_CLZ, 32'h0001_0000, 5'd0, 6'd0, '0, 32'h0, '0));
    directed_rows.push_back(mk_row(CMD_REV, 32'h1234_5678, 5'd0, 6'd0, '1, 32'h7856_3412, '0));
    // field operands are ignored outside the extracts
    directed_rows.push_back(mk_row(CMD_REV, 32'hFFFF_FFFF, 5'd31, 6'd0, '1, 32'hFFFF_FFFF, '0));
    directed_rows.push_back(mk_row(CMD_SXTB, 32'h0000_007F, 5'd31, 6'd63, '1, 32'h0000_007F, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, back to back
    for (i = 0; i < directed_rows.size(); i++) begin
      send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].result, 0);
    end

    // Random part in phases: none, sender idle 71%, none, sender idle 12%
    // (the receiver has no stall input, so its phases run without idling)
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i / PHASE_ITEMS) % 4)
        1:       idle_pct = 71;
        3:       idle_pct = 12;
        default: idle_pct = 0;
      endcase
      send_item(random_item(), 1'b0, '0, idle_pct);
    end
    start <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random commands with %0d sender idle cycles;",
             directed_rows.size(), RANDOM_ITEMS, idle_count);
    $display("%0d results checked, %0d flagged invalid, %0d mismatches in %0d cycles",
             checked_count, invalid_count, err_count, cycle_count);
    if (err_count == 0) begin
      $display("arm_bit_manipulation_unit verification clean");
    end else begin
      $display("arm_bit_manipulation_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/abmu_pkg.sv
hw/rtl/abmu_front.sv
hw/rtl/abmu_queue.sv
hw/rtl/abmu_back.sv
hw/rtl/arm_bit_manipulation_unit.sv
hw/rtl/abmu_checker.sv
bench/tb_arm_bit_manipulation_unit.sv
